[rtl/etc_pkg.sv]
// Package for the epoch-to-calendar converter.
// Holds the reciprocal constants and the month start table. No dependencies.
package etc_pkg;

  localparam int unsigned SECONDS_PER_DAY = 86400;
  localparam int unsigned DAY_SHIFT       = 35;
  localparam logic [25:0] DAY_RECIP       =
      26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);

  localparam int unsigned GROUP_DAYS  = 1461;
  localparam int unsigned GROUP_SHIFT = 27;
  localparam logic [16:0] GROUP_RECIP =
      17'(((64'd1 << GROUP_SHIFT) + 64'd1460) / 64'd1461);

  localparam int unsigned WEEK_SHIFT = 19;
  localparam logic [16:0] WEEK_RECIP =
      17'(((64'd1 << WEEK_SHIFT) + 64'd6) / 64'd7);

  localparam int unsigned HOUR_SHIFT = 21;
  localparam logic [13:0] HOUR_RECIP =
      14'(((64'd1 << HOUR_SHIFT) + 64'd224) / 64'd225);

  localparam int unsigned MIN_SHIFT = 14;
  localparam logic [10:0] MIN_RECIP =
      11'(((64'd1 << MIN_SHIFT) + 64'd14) / 64'd15);

  localparam logic [15:0] DAY_MAR1_2100 = 16'd47541;
  localparam logic [7:0]  YEAR_2100     = 8'd200;
  localparam logic [7:0]  YEAR_GROUP0   = 8'd69;
  localparam logic [8:0]  DAY_MAR1_LEAP = 9'd60;

  localparam logic [3:0] MONTH_JAN = 4'd0;
  localparam logic [3:0] MONTH_FEB = 4'd1;
  localparam logic [3:0] MONTH_MAR = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd3;
  localparam logic [3:0] MONTH_MAY = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd5;
  localparam logic [3:0] MONTH_JUL = 4'd6;
  localparam logic [3:0] MONTH_AUG = 4'd7;
  localparam logic [3:0] MONTH_SEP = 4'd8;
  localparam logic [3:0] MONTH_OCT = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd10;
  localparam logic [3:0] MONTH_DEC = 4'd11;

  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
    logic [8:0] base;
    unique case (mon)
      MONTH_JAN: base = 9'd0;
      MONTH_FEB: base = 9'd31;
      MONTH_MAR: base = 9'd59;
      MONTH_APR: base = 9'd90;
      MONTH_MAY: base = 9'd120;
      MONTH_JUN: base = 9'd151;
      MONTH_JUL: base = 9'd181;
      MONTH_AUG: base = 9'd212;
      MONTH_SEP: base = 9'd243;
      MONTH_OCT: base = 9'd273;
      MONTH_NOV: base = 9'd304;
      MONTH_DEC: base = 9'd334;
      default:   base = 9'd0;
    endcase
    if (leap && (mon >= MONTH_MAR)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

[rtl/etc_in_if.sv]
// Input channel of the epoch-to-calendar converter.
// Carries one timestamp per transfer with a valid/ready handshake. No dependencies.
interface etc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;
  logic        kind;

  modport source (output valid, output epoch_seconds, output kind, input ready);
  modport sink (input valid, input epoch_seconds, input kind, output ready);
endinterface

[rtl/etc_out_if.sv]
// Output channel of the epoch-to-calendar converter.
// Carries one broken-down date per transfer with a valid/ready handshake. No dependencies.
interface etc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] second;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [2:0] weekday;
  logic [7:0] years_since_1900;
  logic [8:0] day_of_year;
  logic [3:0] month_index;
  logic [4:0] day_of_month;

  modport source (output valid, output second, output minute, output hour, output weekday,
                  output years_since_1900, output day_of_year, output month_index,
                  output day_of_month, input ready);
  modport sink (input valid, input second, input minute, input hour, input weekday,
                input years_since_1900, input day_of_year, input month_index,
                input day_of_month, output ready);
endinterface

[rtl/epoch_to_calendar_top.sv]
// Epoch-to-calendar converter top level.
// Depends on etc_pkg, etc_in_if and etc_out_if.
//
// Converts unsigned 32-bit seconds since 1970-01-01 UTC into a Gregorian date and
// time of day (years 1970 to 2106). With kind set, the signed zone offset written
// on the configuration port is subtracted first, modulo 2^32. The block takes one
// transfer per cycle while the output is not stalled; each result passes through the
// eight-stage pipeline of reciprocal multiplies that replaces the divisions by day,
// four-year group, week, hour and minute. Each stage holds its item while the next
// one is full and cannot move on, so a stalled output only backs up as far as the
// first empty stage. The offset should only be written while idle.
module epoch_to_calendar_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic signed [16:0]  cfg_wr_data,
  etc_in_if.sink              stamp,
  etc_out_if.source           calendar
);
  import etc_pkg::*;

  localparam int unsigned NUM_STAGES = 8;

  logic signed [16:0]    zone_offset;
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;

  logic [31:0] t1;
  logic [31:0] t2;
  logic [50:0] p2;
  logic [15:0] days3;
  logic [16:0] sod3;
  logic [15:0] g4;
  logic [33:0] pg4;
  logic [15:0] x4;
  logic [32:0] pw4;
  logic [16:0] sod4;
  logic [26:0] ph4;
  logic [5:0]  q5;
  logic [10:0] r5;
  logic [2:0]  wd5;
  logic [4:0]  hour5;
  logic [11:0] ms5;
  logic [1:0]  yi6;
  logic [8:0]  doy6;
  logic [7:0]  year6;
  logic [20:0] pm6;
  logic [11:0] ms6;
  logic [2:0]  wd6;
  logic [4:0]  hour6;
  logic        leap7;
  logic [3:0]  mon7;
  logic [8:0]  doyph7;
  logic [8:0]  doy7;
  logic [7:0]  year7;
  logic [5:0]  min7;
  logic [11:0] ms7;
  logic [2:0]  wd7;
  logic [4:0]  hour7;

  logic [31:0] t1_next;
  logic [15:0] days3_next;
  logic [31:0] sod3_wide;
  logic [15:0] dph4;
  logic [5:0]  q5_next;
  logic [12:0] qw5;
  logic [15:0] r5_wide;
  logic [15:0] wd5_wide;
  logic [4:0]  hour5_next;
  logic [16:0] ms5_wide;
  logic [1:0]  yi6_next;
  logic [10:0] doy6_wide;
  logic [3:0]  mon7_next;
  logic        fix7;
  logic [8:0]  dom8_wide;
  logic [11:0] sec8_wide;

  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || calendar.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign stamp.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset <= '0;
      vld         <= '0;
    end else begin
      if (cfg_wr_en) begin
        zone_offset <= cfg_wr_data;
      end
      if (adv[0]) begin
        vld[0] <= stamp.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign t1_next = stamp.kind ? (stamp.epoch_seconds - 32'(zone_offset))
                              : stamp.epoch_seconds;

  assign days3_next = p2[50:35];
  assign sod3_wide  = t2 - (32'(days3_next) * 32'(SECONDS_PER_DAY));

  assign dph4 = days3 + ((days3 >= DAY_MAR1_2100) ? 16'd1 : 16'd0);

  assign q5_next    = pg4[32:27];
  assign qw5        = pw4[31:19];
  assign hour5_next = ph4[25:21];
  assign r5_wide    = g4 - (16'(q5_next) * 16'(GROUP_DAYS));
  assign wd5_wide   = x4 - (16'(qw5) * 16'd7);
  assign ms5_wide   = sod4 - (17'(hour5_next) * 17'd3600);

  always_comb begin
    if (r5 >= 11'd1095) begin
      yi6_next = 2'd3;
    end else if (r5 >= 11'd730) begin
      yi6_next = 2'd2;
    end else if (r5 >= 11'd365) begin
      yi6_next = 2'd1;
    end else begin
      yi6_next = 2'd0;
    end
  end

  assign doy6_wide = r5 - (11'(yi6_next) * 11'd365);

  always_comb begin
    mon7_next = MONTH_JAN;
    for (int m = 1; m < 12; m++) begin
      if (doy6 >= month_start(yi6 == 2'd3, 4'(m))) begin
        mon7_next = mon7_next + 4'd1;
      end
    end
  end

  assign fix7 = (year6 == YEAR_2100) && (doy6 >= DAY_MAR1_LEAP);

  assign dom8_wide = doyph7 - month_start(leap7, mon7) + 9'd1;
  assign sec8_wide = ms7 - (12'(min7) * 12'd60);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      t1 <= t1_next;
    end
    if (adv[1]) begin
      t2 <= t1;
      p2 <= 51'(t1[31:7]) * 51'(DAY_RECIP);
    end
    if (adv[2]) begin
      days3 <= days3_next;
      sod3  <= sod3_wide[16:0];
    end
    if (adv[3]) begin
      g4   <= dph4 + 16'd365;
      pg4  <= 34'(dph4 + 16'd365) * 34'(GROUP_RECIP);
      x4   <= days3 + 16'd4;
      pw4  <= 33'(days3 + 16'd4) * 33'(WEEK_RECIP);
      sod4 <= sod3;
      ph4  <= 27'(sod3[16:4]) * 27'(HOUR_RECIP);
    end
    if (adv[4]) begin
      q5    <= q5_next;
      r5    <= r5_wide[10:0];
      wd5   <= wd5_wide[2:0];
      hour5 <= hour5_next;
      ms5   <= ms5_wide[11:0];
    end
    if (adv[5]) begin
      yi6   <= yi6_next;
      doy6  <= doy6_wide[8:0];
      year6 <= YEAR_GROUP0 + {q5, 2'b00} + 8'(yi6_next);
      pm6   <= 21'(ms5[11:2]) * 21'(MIN_RECIP);
      ms6   <= ms5;
      wd6   <= wd5;
      hour6 <= hour5;
    end
    if (adv[6]) begin
      leap7  <= (yi6 == 2'd3);
      mon7   <= mon7_next;
      doyph7 <= doy6;
      doy7   <= doy6 - (fix7 ? 9'd1 : 9'd0);
      year7  <= year6;
      min7   <= pm6[19:14];
      ms7    <= ms6;
      wd7    <= wd6;
      hour7  <= hour6;
    end
    if (adv[7]) begin
      calendar.second           <= sec8_wide[5:0];
      calendar.minute           <= min7;
      calendar.hour             <= hour7;
      calendar.weekday          <= wd7;
      calendar.years_since_1900 <= year7;
      calendar.day_of_year      <= doy7;
      calendar.month_index      <= mon7;
      calendar.day_of_month     <= dom8_wide[4:0];
    end
  end

  assign calendar.valid = vld[NUM_STAGES-1];

endmodule
